// ----- rtl/ipr_pkg.sv -----
`timescale 1ns / 1ps

package ipr_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned VALUE_BITS_DEF  = 32;
  localparam int unsigned IN_VALUE_W      = 32;
  localparam int unsigned HELD_W          = 11;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_ORDER = 2'd2;

  typedef struct packed {
    logic [1:0]            mode;
    logic [IN_VALUE_W-1:0] value_in;
  } in_t;

  typedef struct packed {
    logic              found;
    logic [1:0]        status;
    logic [HELD_W-1:0] ranges_held;
  } out_t;

  typedef struct packed {
    logic done;
    logic hit;
  } srch_res_t;

endpackage

// ----- rtl/ip_range_table_binary_search.sv -----
`timescale 1ns / 1ps

// Range table with binary-search lookup. Load transactions (strictly ascending values)
// grow the open range or close it into the table; a query returns found when the
// value lies in a stored range or the open range. Clear and load transactions
// complete without a search, with the result registered in the cycle after they are
// taken. A query runs one probe per cycle on the range-start memory read port and its
// comparator: floor(log2(N))+1 probes for N stored ranges (none when empty), then a
// final range check in the search unit, whose registered result is moved into the
// output register. Input is taken only when no query is in flight and the output
// register is free or being emptied. Table memories need no clearing after reset:
// only entries below the range count can affect a result.
module ip_range_table_binary_search #(
  parameter int unsigned TABLE_DEPTH = ipr_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = ipr_pkg::VALUE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ipr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ipr_pkg::out_t out_data_o
);

  import ipr_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic                  accept;
  logic [VALUE_BITS-1:0] key;
  logic [VALUE_BITS:0]   next_val;
  logic                  open_hit;

  logic                  busy_q, busy_d;
  logic [CW-1:0]         count_q, count_d;
  logic [VALUE_BITS-1:0] open_first_q, open_first_d, open_last_q, open_last_d;
  logic                  open_valid_q, open_valid_d;
  logic [VALUE_BITS-1:0] key_q, key_d;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q, out_d;

  logic                  wr_en;
  logic [AW-1:0]         first_addr, last_addr;
  logic [VALUE_BITS-1:0] first_data, last_data;
  srch_res_t             srch_res;

  assign in_ready_o = !busy_q && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign key        = VALUE_BITS'(in_data_i.value_in);
  assign next_val   = {1'b0, open_last_q} + (VALUE_BITS + 1)'(1);
  assign open_hit   = open_valid_q && (key_q >= open_first_q) && (key_q <= open_last_q);

  always_comb begin
    busy_d       = busy_q;
    count_d      = count_q;
    open_first_d = open_first_q;
    open_last_d  = open_last_q;
    open_valid_d = open_valid_q;
    key_d        = key_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    wr_en        = 1'b0;
    if (accept) begin
      out_valid_d       = 1'b1;
      out_d.found       = 1'b0;
      out_d.status      = STAT_OK;
      unique case (in_data_i.mode)
        MODE_CLEAR: begin
          count_d      = '0;
          open_valid_d = 1'b0;
          open_first_d = '0;
          open_last_d  = '0;
        end
        MODE_LOAD: begin
          priority if (!open_valid_q) begin
            open_valid_d = 1'b1;
            open_first_d = key;
            open_last_d  = key;
          end else if (key <= open_last_q) begin
            out_d.status = STAT_ORDER;
          end else if ({1'b0, key} == next_val) begin
            open_last_d = key;
          end else if (count_q >= CW'(TABLE_DEPTH)) begin
            out_d.status = STAT_FULL;
          end else begin
            wr_en        = 1'b1;
            count_d      = count_q + CW'(1);
            open_first_d = key;
            open_last_d  = key;
          end
        end
        MODE_QUERY: begin
          busy_d      = 1'b1;
          key_d       = key;
          out_valid_d = 1'b0;
        end
        default: ;
      endcase
      out_d.ranges_held = HELD_W'(count_d);
    end
    if (srch_res.done) begin
      busy_d            = 1'b0;
      out_valid_d       = 1'b1;
      out_d.found       = srch_res.hit || open_hit;
      out_d.status      = STAT_OK;
      out_d.ranges_held = HELD_W'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      count_q      <= '0;
      open_first_q <= '0;
      open_last_q  <= '0;
      open_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      busy_q       <= busy_d;
      count_q      <= count_d;
      open_first_q <= open_first_d;
      open_last_q  <= open_last_d;
      open_valid_q <= open_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    out_q <= out_d;
  end

  ipr_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_table (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (count_q[AW-1:0]),
    .wr_first_i  (open_first_q),
    .wr_last_i   (open_last_q),
    .first_addr_i(first_addr),
    .last_addr_i (last_addr),
    .first_data_o(first_data),
    .last_data_o (last_data)
  );

  ipr_search #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept && (in_data_i.mode == MODE_QUERY)),
    .key_i       (busy_q ? key_q : key),
    .count_i     (count_q),
    .first_data_i(first_data),
    .last_data_i (last_data),
    .first_addr_o(first_addr),
    .last_addr_o (last_addr),
    .res_o       (srch_res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/ipr_table.sv -----
`timescale 1ns / 1ps

module ipr_table #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned VALUE_BITS  = 32,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  logic [VALUE_BITS-1:0] wr_first_i,
  input  logic [VALUE_BITS-1:0] wr_last_i,
  input  logic [AW-1:0]         first_addr_i,
  input  logic [AW-1:0]         last_addr_i,
  output logic [VALUE_BITS-1:0] first_data_o,
  output logic [VALUE_BITS-1:0] last_data_o
);

  logic [VALUE_BITS-1:0] first_mem [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] last_mem  [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      first_mem[wr_addr_i] <= wr_first_i;
      last_mem[wr_addr_i]  <= wr_last_i;
    end
    first_data_o <= first_mem[first_addr_i];
    last_data_o  <= last_mem[last_addr_i];
  end

endmodule

// ----- rtl/ipr_search.sv -----
`timescale 1ns / 1ps

module ipr_search #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned VALUE_BITS  = 32,
  localparam int unsigned AW = $clog2(TABLE_DEPTH),
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] key_i,
  input  logic [CW-1:0]         count_i,
  input  logic [VALUE_BITS-1:0] first_data_i,
  input  logic [VALUE_BITS-1:0] last_data_i,
  output logic [AW-1:0]         first_addr_o,
  output logic [AW-1:0]         last_addr_o,
  output ipr_pkg::srch_res_t    res_o
);

  import ipr_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_CHECK} state_e;

  state_e    state_q, state_d;
  logic [CW-1:0] base_q, base_d, span_q, span_d;
  logic [CW-1:0] half, upper, probe, last_idx;
  srch_res_t res_q, res_d;

  always_comb begin
    state_d = state_q;
    base_d  = base_q;
    span_d  = span_q;
    res_d   = '0;
    half    = span_q >> 1;
    upper   = base_q + (span_q - half);
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          base_d = '0;
          span_d = count_i;
        end
      end
      S_SEARCH: begin
        span_d = half;
        base_d = (first_data_i >= key_i) ? base_q : upper;
      end
      S_CHECK: begin
        res_d.done = 1'b1;
        res_d.hit  = ((base_q < count_i) && (first_data_i == key_i)) ||
                     ((base_q != '0) && (key_i <= last_data_i));
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if ((state_q == S_IDLE && start_i) || state_q == S_SEARCH) begin
      state_d = (span_d != '0) ? S_SEARCH : S_CHECK;
    end
    probe        = base_d + (span_d >> 1);
    last_idx     = base_d - CW'(1);
    first_addr_o = probe[AW-1:0];
    last_addr_o  = last_idx[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      base_q  <= '0;
      span_q  <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      span_q  <= span_d;
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- rtl/ipr_checker.sv -----
`timescale 1ns / 1ps

module ipr_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input ipr_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input ipr_pkg::out_t out_data_o
);

  import ipr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result slot blocked");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |-> out_data_o.status == STAT_OK)
    else $error("hit reported with error status");

  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.mode == MODE_CLEAR |=>
      out_valid_o && out_data_o.ranges_held == '0 && !out_data_o.found)
    else $error("clear transaction result wrong");

endmodule

bind ip_range_table_binary_search ipr_checker u_ipr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
